FILE: design/bbfp_pkg.sv
// Shared constants, types and helpers for the backward bit-field packer.
package bbfp_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CAP_W       = 11;
    localparam int VALUE_W     = 64;
    localparam int TOP_W       = 6;
    localparam int REM_W       = 7;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_REWIND = 2'd2;

    typedef struct packed {
        logic [7:0]       val_top;
        logic [7:0]       rd_byte;
        logic [2:0]       bit_pos;
        logic [REM_W-1:0] rem;
    } unit_in_t;

    typedef struct packed {
        logic [7:0] wr_byte;
        logic [7:0] got;
        logic [3:0] n;
        logic [2:0] lo;
        logic       wrap;
    } unit_out_t;

    function automatic logic [ADDR_W-1:0] last_byte(input logic [CAP_W-1:0] cap);
        logic [CAP_W:0] c;
        c = {1'b0, cap};
        if (c == '0)
            c = (CAP_W+1)'(1);
        if (c > (CAP_W+1)'(STORE_BYTES))
            c = (CAP_W+1)'(STORE_BYTES);
        c = c - (CAP_W+1)'(1);
        return c[ADDR_W-1:0];
    endfunction

endpackage

FILE: design/bbfp_store.sv
// Byte store: one write port and one registered read port.
module bbfp_store
    import bbfp_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/bbfp_byte_unit.sv
// Shared byte unit: merges or extracts the field bits that fall in one store byte.
module bbfp_byte_unit
    import bbfp_pkg::*;
(
    input  unit_in_t  u_in,
    output unit_out_t u_out
);

    logic [3:0] avail;
    logic [3:0] n;
    logic [2:0] lo;
    logic [7:0] low_ones;
    logic [7:0] mask;
    logic [7:0] chunk;
    logic [8:0] ones_wide;

    always_comb
    begin
        avail     = {1'b0, u_in.bit_pos} + 4'd1;
        if (u_in.rem < {3'b000, avail})
            n = u_in.rem[3:0];
        else
            n = avail;
        lo        = 3'(avail - n);
        ones_wide = (9'd1 << n) - 9'd1;
        low_ones  = ones_wide[7:0];
        mask      = low_ones << lo;
        chunk     = u_in.val_top >> (4'd8 - n);
        u_out.wr_byte = (u_in.rd_byte & ~mask) | ((chunk << lo) & mask);
        u_out.got     = (u_in.rd_byte >> lo) & low_ones;
        u_out.n       = n;
        u_out.lo      = lo;
        u_out.wrap    = (n == avail);
    end

endmodule

FILE: design/backward_bit_field_packer.sv
// Backward bit-field packer top level: sequencer, cursor and result register.
//
// A field write or read (2 to 64 bits) first fetches the byte under the
// cursor, then works through each store byte the field touches, one at a time
// via the byte unit and the single store port pair. Rewind, an unused func
// code and a zero top_bit finish from idle. The result appears on read_value
// and error with done, high for a single cycle; read_value and error hold
// until the next start, and the receiver cannot stall them. After reset the
// block clears all 1024 store bytes, one per cycle, with busy high;
// configuration writes are taken at any time and also rewind the cursor.
module backward_bit_field_packer
    import bbfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [VALUE_W-1:0] value,
    input  logic [TOP_W-1:0]   top_bit,
    output logic               done,
    output logic [VALUE_W-1:0] read_value,
    output logic               error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CAP_W-1:0]   capacity_bytes
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [ADDR_W-1:0]  byte_reg, byte_next;
    logic [2:0]         bit_reg, bit_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [1:0]         func_reg, func_next;
    logic               done_reg, done_next;
    logic [VALUE_W-1:0] rv_reg, rv_next;
    logic               err_reg, err_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    unit_in_t          u_in;
    unit_out_t         u_out;
    logic              run_err;
    logic [REM_W-1:0]  rem_left;
    logic [VALUE_W-1:0] acc_new;

    bbfp_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbfp_byte_unit u_unit (
        .u_in  (u_in),
        .u_out (u_out)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done       = done_reg;
    assign read_value = rv_reg;
    assign error      = err_reg;

    always_comb
    begin
        u_in.val_top = val_reg[VALUE_W-1 -: 8];
        u_in.rd_byte = rd_data;
        u_in.bit_pos = bit_reg;
        u_in.rem     = rem_reg;
        run_err      = u_out.wrap && (byte_reg == '0);
        rem_left     = rem_reg - REM_W'(u_out.n);
        acc_new      = (acc_reg << u_out.n) | VALUE_W'(u_out.got);
    end

    always_comb
    begin
        if (state_reg == S_MERGE)
            rd_addr = byte_reg - ADDR_W'(1);
        else
            rd_addr = byte_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cap_next   = cap_reg;
        byte_next  = byte_reg;
        bit_next   = bit_reg;
        val_next   = val_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        func_next  = func_reg;
        done_next  = 1'b0;
        rv_next    = rv_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        wr_addr    = byte_reg;
        wr_data    = u_out.wr_byte;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = 8'h00;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_BYTES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    rv_next  = '0;
                    err_next = 1'b0;
                    if (func == FUNC_REWIND)
                    begin
                        byte_next = last_byte(cap_reg);
                        bit_next  = 3'd7;
                        done_next = 1'b1;
                    end
                    else if (func != FUNC_WRITE && func != FUNC_READ)
                    begin
                        done_next = 1'b1;
                    end
                    else if (top_bit == '0)
                    begin
                        err_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        val_next   = value << (TOP_W'(VALUE_W - 1) - top_bit);
                        acc_next   = '0;
                        rem_next   = REM_W'(top_bit) + REM_W'(1);
                        func_next  = func;
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                wr_en    = (func_reg == FUNC_WRITE);
                val_next = val_reg << u_out.n;
                acc_next = acc_new;
                rem_next = rem_left;
                if (run_err)
                begin
                    bit_next = 3'd0;
                end
                else if (u_out.wrap)
                begin
                    byte_next = byte_reg - ADDR_W'(1);
                    bit_next  = 3'd7;
                end
                else
                begin
                    bit_next = u_out.lo - 3'd1;
                end
                if (run_err || rem_left == '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    err_next   = run_err;
                    if (func_reg == FUNC_READ && !run_err)
                        rv_next = acc_new;
                    else
                        rv_next = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            cap_next  = capacity_bytes;
            byte_next = last_byte(capacity_bytes);
            bit_next  = 3'd7;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            cap_reg   <= CAP_W'(1024);
            byte_reg  <= last_byte(CAP_W'(1024));
            bit_reg   <= 3'd7;
            done_reg  <= 1'b0;
            func_reg  <= FUNC_WRITE;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cap_reg   <= cap_next;
            byte_reg  <= byte_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
            func_reg  <= func_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        acc_reg <= acc_next;
        rv_reg  <= rv_next;
        err_reg <= err_next;
    end

endmodule
